>>> src/ffca_pkg.sv
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared types and constants for the first-fit coalescing pool allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

	localparam int DATA_BITS  = 32;
	localparam int LEN_BITS   = 32;
	localparam int ALIGN_BITS = 4;
	localparam int PAD_BITS   = 16;

	typedef enum logic [0:0] {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_FIT    = 2'd1,
		ST_NOT_ALLOC = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_POOL_BASE   = 2'd0,
		CFG_POOL_LENGTH = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		cmd_t                    command;
		logic [DATA_BITS-1:0]    request_bytes;
		logic [ALIGN_BITS-1:0]   align_log2;
		logic [DATA_BITS-1:0]    free_address;
	} req_t;

	typedef struct packed {
		status_t                 status;
		logic [DATA_BITS-1:0]    address;
	} rsp_t;

	typedef struct packed {
		logic rec_write;
		logic set_valid;
		logic clr_valid;
		logic clr_all;
	} used_ctl_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_A_RD,
		S_A_PAD,
		S_A_NEED,
		S_A_FIT,
		S_A_ADDR,
		S_U_SCAN,
		S_A_SHR,
		S_DN,
		S_DNW,
		S_A_REC,
		S_F_RD,
		S_F_CMP,
		S_F_MP,
		S_F_MN,
		S_F_SAT1,
		S_F_SAT2,
		S_F_UP,
		S_F_UPW,
		S_F_CLR,
		S_FIN
	} state_t;

endpackage

>>> src/ffca_alu.sv
// ----------------------------------------------------------------------------
// ffca_alu
// Shared adder/subtractor; the carry out doubles as the a >= b flag.
// ----------------------------------------------------------------------------
module ffca_alu #(
	parameter int W = 33
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W:0]   sum
);

	logic [W-1:0] b_eff;

	assign b_eff = sub ? ~b : b;
	assign sum   = {1'b0, a} + {1'b0, b_eff} + {{W{1'b0}}, sub};

endmodule

>>> src/ffca_used_tbl.sv
// ----------------------------------------------------------------------------
// ffca_used_tbl
// Allocation record table: address/length memory plus per-entry valid bits.
// ----------------------------------------------------------------------------
module ffca_used_tbl #(
	parameter int ADDR_BITS    = 32,
	parameter int USED_ENTRIES = 32,
	localparam int IW          = $clog2(USED_ENTRIES)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ffca_pkg::used_ctl_t           ctl,
	input  logic [IW-1:0]                 rd_idx,
	output logic [ADDR_BITS-1:0]          rd_addr,
	output logic [ffca_pkg::LEN_BITS-1:0] rd_len,
	input  logic [IW-1:0]                 vld_idx,
	output logic                          vld_bit,
	input  logic [IW-1:0]                 wr_idx,
	input  logic [ADDR_BITS-1:0]          wr_addr,
	input  logic [ffca_pkg::LEN_BITS-1:0] wr_len
);

	logic [ADDR_BITS-1:0]          addr_mem [USED_ENTRIES];
	logic [ffca_pkg::LEN_BITS-1:0] len_mem  [USED_ENTRIES];
	logic [USED_ENTRIES-1:0]       valid_q;

	always_ff @(posedge clk) begin
		if (ctl.rec_write) begin
			addr_mem[wr_idx] <= wr_addr;
			len_mem[wr_idx]  <= wr_len;
		end
		rd_addr <= addr_mem[rd_idx];
		rd_len  <= len_mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clr_all) begin
			valid_q <= '0;
		end else begin
			if (ctl.set_valid) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (ctl.clr_valid) begin
				valid_q[wr_idx] <= 1'b0;
			end
		end
	end

	assign vld_bit = valid_q[vld_idx];

endmodule

>>> src/first_fit_coalescing_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator
// First-fit pool allocator with ordered free list and merge on release.
//
//  channel | signals                          | direction
//  req     | req_valid, req_ready, req        | in
//  rsp     | rsp_valid, rsp_ready, rsp        | out
//  cfg     | cfg_valid, cfg_ready, cfg_index, | in
//          | cfg_data                         |
//
// One request at a time. Allocate: tries free entries in order, then scans the
// record table and moves entries down when a block is removed. Free: record
// scan, then a walk of the free list, moving entries on insert or merge. All
// steps share the one adder and the free list memory with one read and one
// write port. Reset and pool writes leave one free block.
// The result register holds while rsp_ready is low; the next result waits.
// ----------------------------------------------------------------------------
module first_fit_coalescing_allocator #(
	parameter int FREE_ENTRIES = 16,
	parameter int USED_ENTRIES = 32,
	parameter int ADDR_BITS    = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  ffca_pkg::req_t                 req,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output ffca_pkg::rsp_t                 rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [1:0]                     cfg_index,
	input  logic [ffca_pkg::DATA_BITS-1:0] cfg_data
);

	localparam int DW  = (ADDR_BITS > 32) ? ADDR_BITS : 32;
	localparam int AW  = DW + 1;
	localparam int FIW = $clog2(FREE_ENTRIES);
	localparam int FCW = $clog2(FREE_ENTRIES + 1);
	localparam int UIW = $clog2(USED_ENTRIES);
	localparam int UCW = $clog2(USED_ENTRIES + 1);
	localparam int LB  = ffca_pkg::LEN_BITS;
	localparam int PB  = ffca_pkg::PAD_BITS;

	ffca_pkg::state_t state_q, state_d;

	// free list memory
	logic [ADDR_BITS-1:0] fm_start [FREE_ENTRIES];
	logic [LB-1:0]        fm_len   [FREE_ENTRIES];
	logic [ADDR_BITS-1:0] fm_start_q;
	logic [LB-1:0]        fm_len_q;
	logic                 rd0_q, init_q;
	logic [FIW-1:0]       fm_raddr, fm_waddr;
	logic                 fm_we;
	logic [ADDR_BITS-1:0] fm_ws, fm_rs;
	logic [LB-1:0]        fm_wl, fm_rl;

	logic [FCW-1:0] fcnt_q, fk_q, pos_q, fk_inc, fk_dec;
	logic [UCW-1:0] uk_q;
	logic [UIW-1:0] ff_q, slot_q, u_j;
	logic           ff_seen_q;
	ffca_pkg::cmd_t cmd_q;
	logic [LB-1:0]  bytes_q, diff_q, ulen_q, prev_l_q, next_l_q, t_q, cur_l_q;
	logic [ffca_pkg::ALIGN_BITS-1:0] lg_q;
	logic [ADDR_BITS-1:0] key_q, cur_s_q, prev_s_q, next_s_q, base_q;
	logic [LB-1:0]  plen_q;
	logic [PB-1:0]  pad_q, mask;
	logic [AW-1:0]  need_q;
	logic           gt_q, mp_q, mn_q;
	ffca_pkg::status_t res_st_q;
	logic [ffca_pkg::DATA_BITS-1:0] res_addr_q;
	logic           rsp_valid_q;
	ffca_pkg::rsp_t rsp_q;

	// shared adder
	logic [AW-1:0] alu_a, alu_b;
	logic          alu_sub;
	logic [AW:0]   alu_sum;
	logic          sum_ge;
	logic [ADDR_BITS-1:0] sum_lo;
	logic [LB-1:0] sat;

	// record table
	ffca_pkg::used_ctl_t  u_ctl;
	logic [ADDR_BITS-1:0] u_rd_addr;
	logic [LB-1:0]        u_rd_len;
	logic                 u_vld_bit, u_hit, u_free, u_end, u_found;

	logic cfg_hit, cfg_take, req_take, fin_go, mn_now;

	ffca_alu #(.W(AW)) u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.sum (alu_sum)
	);

	ffca_used_tbl #(.ADDR_BITS(ADDR_BITS), .USED_ENTRIES(USED_ENTRIES)) u_used (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (u_ctl),
		.rd_idx  (uk_q[UIW-1:0]),
		.rd_addr (u_rd_addr),
		.rd_len  (u_rd_len),
		.vld_idx (u_j),
		.vld_bit (u_vld_bit),
		.wr_idx  (slot_q),
		.wr_addr (key_q),
		.wr_len  (bytes_q)
	);

	assign sum_ge = alu_sum[AW];
	assign sum_lo = alu_sum[ADDR_BITS-1:0];
	assign sat    = (|alu_sum[AW:LB]) ? {LB{1'b1}} : alu_sum[LB-1:0];
	assign mask   = (PB'(1) << lg_q) - PB'(1);
	assign fk_inc = fk_q + FCW'(1);
	assign fk_dec = fk_q - FCW'(1);

	// record scan compares the registered read of the previous index (u_j)
	assign u_j     = UIW'(uk_q - UCW'(1));
	assign u_hit   = (uk_q != '0) && u_vld_bit && (u_rd_addr == key_q);
	assign u_free  = (uk_q != '0) && !u_vld_bit;
	assign u_end   = (uk_q == UCW'(USED_ENTRIES));
	assign u_found = u_hit || ff_seen_q || u_free;
	assign mn_now  = (pos_q < fcnt_q) && (sum_lo == next_s_q);

	// entry 0 reads as the reset block until first written
	assign fm_rs = rd0_q ? '0 : fm_start_q;
	assign fm_rl = rd0_q ? '0 : fm_len_q;

	assign cfg_hit   = (cfg_index == ffca_pkg::CFG_POOL_BASE) ||
	                   (cfg_index == ffca_pkg::CFG_POOL_LENGTH);
	assign cfg_ready = (state_q == ffca_pkg::S_IDLE);
	assign req_ready = (state_q == ffca_pkg::S_IDLE) && !cfg_valid;
	assign cfg_take  = cfg_valid && cfg_ready;
	assign req_take  = req_valid && req_ready;
	assign fin_go    = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffca_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		fm_raddr = fk_q[FIW-1:0];
		fm_we    = 1'b0;
		fm_waddr = fk_q[FIW-1:0];
		fm_ws    = key_q;
		fm_wl    = ulen_q;
		u_ctl    = '0;
		alu_a    = '0;
		alu_b    = '0;
		alu_sub  = 1'b0;
		case (state_q)
			ffca_pkg::S_IDLE: begin
				if (cfg_take && cfg_hit) begin
					fm_we    = 1'b1;
					fm_waddr = '0;
					fm_ws    = (cfg_index == ffca_pkg::CFG_POOL_BASE) ?
					           ADDR_BITS'(cfg_data) : base_q;
					fm_wl    = (cfg_index == ffca_pkg::CFG_POOL_LENGTH) ? cfg_data : plen_q;
					u_ctl.clr_all = 1'b1;
				end else if (req_take) begin
					state_d = (req.command == ffca_pkg::CMD_ALLOC) ?
					          ffca_pkg::S_A_RD : ffca_pkg::S_U_SCAN;
				end
			end
			ffca_pkg::S_A_RD: begin
				state_d = (fk_q < fcnt_q) ? ffca_pkg::S_A_PAD : ffca_pkg::S_FIN;
			end
			ffca_pkg::S_A_PAD: begin
				alu_b   = AW'(fm_rs);
				alu_sub = 1'b1;
				state_d = ffca_pkg::S_A_NEED;
			end
			ffca_pkg::S_A_NEED: begin
				alu_a   = AW'(bytes_q);
				alu_b   = AW'(pad_q);
				state_d = ffca_pkg::S_A_FIT;
			end
			ffca_pkg::S_A_FIT: begin
				alu_a   = AW'(cur_l_q);
				alu_b   = need_q;
				alu_sub = 1'b1;
				state_d = sum_ge ? ffca_pkg::S_A_ADDR : ffca_pkg::S_A_RD;
			end
			ffca_pkg::S_A_ADDR: begin
				alu_a   = AW'(cur_s_q);
				alu_b   = AW'(pad_q);
				state_d = ffca_pkg::S_U_SCAN;
			end
			ffca_pkg::S_U_SCAN: begin
				if (u_hit || u_end) begin
					if (cmd_q == ffca_pkg::CMD_ALLOC) begin
						if (u_found) begin
							state_d = gt_q ? ffca_pkg::S_A_SHR : ffca_pkg::S_DN;
						end else begin
							state_d = ffca_pkg::S_FIN;
						end
					end else if (u_hit) begin
						state_d = (u_rd_len == '0) ? ffca_pkg::S_F_CLR : ffca_pkg::S_F_RD;
					end else begin
						state_d = ffca_pkg::S_FIN;
					end
				end
			end
			ffca_pkg::S_A_SHR: begin
				alu_a   = AW'(cur_s_q);
				alu_b   = need_q;
				fm_we   = 1'b1;
				fm_ws   = sum_lo;
				fm_wl   = diff_q;
				state_d = ffca_pkg::S_A_REC;
			end
			ffca_pkg::S_DN: begin
				// close the gap left by a removed entry
				if (fk_inc < fcnt_q) begin
					fm_raddr = fk_inc[FIW-1:0];
					state_d  = ffca_pkg::S_DNW;
				end else begin
					state_d = (cmd_q == ffca_pkg::CMD_ALLOC) ?
					          ffca_pkg::S_A_REC : ffca_pkg::S_F_CLR;
				end
			end
			ffca_pkg::S_DNW: begin
				fm_we   = 1'b1;
				fm_ws   = fm_rs;
				fm_wl   = fm_rl;
				state_d = ffca_pkg::S_DN;
			end
			ffca_pkg::S_A_REC: begin
				u_ctl.rec_write = 1'b1;
				u_ctl.set_valid = 1'b1;
				state_d         = ffca_pkg::S_FIN;
			end
			ffca_pkg::S_F_RD: begin
				state_d = (fk_q < fcnt_q) ? ffca_pkg::S_F_CMP : ffca_pkg::S_F_MP;
			end
			ffca_pkg::S_F_CMP: begin
				alu_a   = AW'(key_q);
				alu_b   = AW'(fm_rs);
				alu_sub = 1'b1;
				state_d = sum_ge ? ffca_pkg::S_F_RD : ffca_pkg::S_F_MP;
			end
			ffca_pkg::S_F_MP: begin
				alu_a   = AW'(prev_s_q);
				alu_b   = AW'(prev_l_q);
				state_d = ffca_pkg::S_F_MN;
			end
			ffca_pkg::S_F_MN: begin
				alu_a = AW'(key_q);
				alu_b = AW'(ulen_q);
				if (mp_q || mn_now) begin
					state_d = ffca_pkg::S_F_SAT1;
				end else if (fcnt_q == FCW'(FREE_ENTRIES)) begin
					state_d = ffca_pkg::S_FIN;
				end else begin
					state_d = ffca_pkg::S_F_UP;
				end
			end
			ffca_pkg::S_F_SAT1: begin
				alu_a = AW'(mp_q ? prev_l_q : next_l_q);
				alu_b = AW'(ulen_q);
				if (mp_q && mn_q) begin
					state_d = ffca_pkg::S_F_SAT2;
				end else if (mp_q) begin
					fm_we    = 1'b1;
					fm_waddr = FIW'(pos_q - FCW'(1));
					fm_ws    = prev_s_q;
					fm_wl    = sat;
					state_d  = ffca_pkg::S_F_CLR;
				end else begin
					fm_we    = 1'b1;
					fm_waddr = pos_q[FIW-1:0];
					fm_ws    = key_q;
					fm_wl    = sat;
					state_d  = ffca_pkg::S_F_CLR;
				end
			end
			ffca_pkg::S_F_SAT2: begin
				alu_a    = AW'(t_q);
				alu_b    = AW'(next_l_q);
				fm_we    = 1'b1;
				fm_waddr = FIW'(pos_q - FCW'(1));
				fm_ws    = prev_s_q;
				fm_wl    = sat;
				state_d  = ffca_pkg::S_DN;
			end
			ffca_pkg::S_F_UP: begin
				// open a slot at pos, moving entries up from the tail
				if (fk_q > pos_q) begin
					fm_raddr = fk_dec[FIW-1:0];
					state_d  = ffca_pkg::S_F_UPW;
				end else begin
					fm_we    = 1'b1;
					fm_waddr = pos_q[FIW-1:0];
					fm_ws    = key_q;
					fm_wl    = ulen_q;
					state_d  = ffca_pkg::S_F_CLR;
				end
			end
			ffca_pkg::S_F_UPW: begin
				fm_we   = 1'b1;
				fm_ws   = fm_rs;
				fm_wl   = fm_rl;
				state_d = ffca_pkg::S_F_UP;
			end
			ffca_pkg::S_F_CLR: begin
				u_ctl.clr_valid = 1'b1;
				state_d         = ffca_pkg::S_FIN;
			end
			ffca_pkg::S_FIN: begin
				if (fin_go) begin
					state_d = ffca_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ffca_pkg::S_IDLE;
			end
		endcase
	end

	// free list memory
	always_ff @(posedge clk) begin
		if (fm_we) begin
			fm_start[fm_waddr] <= fm_ws;
			fm_len[fm_waddr]   <= fm_wl;
		end
		fm_start_q <= fm_start[fm_raddr];
		fm_len_q   <= fm_len[fm_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= 1'b0;
			rd0_q  <= 1'b0;
		end else begin
			rd0_q <= (fm_raddr == '0) && !init_q;
			if (fm_we && (fm_waddr == '0)) begin
				init_q <= 1'b1;
			end
		end
	end

	// control counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q      <= FCW'(1);
			base_q      <= '0;
			plen_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_take && cfg_hit) begin
				fcnt_q <= FCW'(1);
				if (cfg_index == ffca_pkg::CFG_POOL_BASE) begin
					base_q <= ADDR_BITS'(cfg_data);
				end else begin
					plen_q <= cfg_data;
				end
			end
			if (state_q == ffca_pkg::S_DN && !(fk_inc < fcnt_q)) begin
				fcnt_q <= fcnt_q - FCW'(1);
			end
			if (state_q == ffca_pkg::S_F_UP && !(fk_q > pos_q)) begin
				fcnt_q <= fcnt_q + FCW'(1);
			end
			if (state_q == ffca_pkg::S_FIN && fin_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ffca_pkg::S_IDLE: begin
				if (req_take) begin
					cmd_q     <= req.command;
					bytes_q   <= req.request_bytes;
					lg_q      <= req.align_log2;
					key_q     <= ADDR_BITS'(req.free_address);
					fk_q      <= '0;
					uk_q      <= '0;
					ff_seen_q <= 1'b0;
				end
			end
			ffca_pkg::S_A_RD: begin
				if (!(fk_q < fcnt_q)) begin
					res_st_q   <= ffca_pkg::ST_NO_FIT;
					res_addr_q <= '0;
				end
			end
			ffca_pkg::S_A_PAD: begin
				cur_s_q <= fm_rs;
				cur_l_q <= fm_rl;
				pad_q   <= alu_sum[PB-1:0] & mask;
			end
			ffca_pkg::S_A_NEED: begin
				need_q <= alu_sum[AW-1:0];
			end
			ffca_pkg::S_A_FIT: begin
				diff_q <= alu_sum[LB-1:0];
				gt_q   <= (alu_sum[AW-1:0] != '0);
				if (!sum_ge) begin
					fk_q <= fk_inc;
				end
			end
			ffca_pkg::S_A_ADDR: begin
				key_q     <= sum_lo;
				uk_q      <= '0;
				ff_seen_q <= 1'b0;
			end
			ffca_pkg::S_U_SCAN: begin
				uk_q <= uk_q + UCW'(1);
				if (u_free && !ff_seen_q) begin
					ff_seen_q <= 1'b1;
					ff_q      <= u_j;
				end
				slot_q <= (u_hit || !ff_seen_q) ? u_j : ff_q;
				ulen_q <= u_rd_len;
				if (u_hit || u_end) begin
					if (cmd_q == ffca_pkg::CMD_ALLOC) begin
						res_st_q <= ffca_pkg::ST_FULL;
					end else begin
						res_st_q <= ffca_pkg::ST_NOT_ALLOC;
						fk_q     <= '0;
					end
					res_addr_q <= '0;
				end
			end
			ffca_pkg::S_DNW: begin
				fk_q <= fk_inc;
			end
			ffca_pkg::S_A_REC: begin
				res_st_q   <= ffca_pkg::ST_OK;
				res_addr_q <= ffca_pkg::DATA_BITS'(key_q);
			end
			ffca_pkg::S_F_RD: begin
				if (!(fk_q < fcnt_q)) begin
					pos_q <= fk_q;
				end
			end
			ffca_pkg::S_F_CMP: begin
				if (sum_ge) begin
					prev_s_q <= fm_rs;
					prev_l_q <= fm_rl;
					fk_q     <= fk_inc;
				end else begin
					pos_q    <= fk_q;
					next_s_q <= fm_rs;
					next_l_q <= fm_rl;
				end
			end
			ffca_pkg::S_F_MP: begin
				mp_q <= (pos_q != '0) && (sum_lo == key_q);
			end
			ffca_pkg::S_F_MN: begin
				mn_q       <= mn_now;
				fk_q       <= fcnt_q;
				res_st_q   <= ffca_pkg::ST_FULL;
				res_addr_q <= '0;
			end
			ffca_pkg::S_F_SAT1: begin
				t_q <= sat;
			end
			ffca_pkg::S_F_SAT2: begin
				fk_q <= pos_q;
			end
			ffca_pkg::S_F_UPW: begin
				fk_q <= fk_dec;
			end
			ffca_pkg::S_F_CLR: begin
				res_st_q   <= ffca_pkg::ST_OK;
				res_addr_q <= '0;
			end
			ffca_pkg::S_FIN: begin
				if (fin_go) begin
					rsp_q.status  <= res_st_q;
					rsp_q.address <= res_addr_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_fcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= FCW'(FREE_ENTRIES))
		else $error("free list count above capacity");

	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> state_q != ffca_pkg::S_IDLE)
		else $error("accepted request did not start");

	a_err_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ffca_pkg::ST_OK |-> rsp.address == '0)
		else $error("failed request returned an address");

	a_cfg_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_take && cfg_hit |=> fcnt_q == FCW'(1) && state_q == ffca_pkg::S_IDLE)
		else $error("pool write did not rebuild free list");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ffca_pkg::S_U_SCAN |-> uk_q <= UCW'(USED_ENTRIES))
		else $error("record scan ran past table");
`endif

endmodule

>>> test/ffca_checker.sv
// ----------------------------------------------------------------------------
// ffca_checker
// Watches the request, response and register channels of the pool allocator,
// keeps its own free list and record table, predicts the response of every
// accepted request and compares it field by field with what comes back.
// ----------------------------------------------------------------------------
module ffca_checker #(
	parameter int FREE_ENTRIES = 16,
	parameter int USED_ENTRIES = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	input  logic                           req_ready,
	input  ffca_pkg::req_t                 req,
	input  logic                           rsp_valid,
	input  logic                           rsp_ready,
	input  ffca_pkg::rsp_t                 rsp,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [1:0]                     cfg_index,
	input  logic [ffca_pkg::DATA_BITS-1:0] cfg_data,
	output int                             errors,
	output int                             pending,
	output int                             n_alloc,
	output int                             n_free,
	output int                             n_status [4]
);

	logic [31:0]    base_q, plen_q;
	logic [31:0]    fs [FREE_ENTRIES];
	logic [31:0]    fl [FREE_ENTRIES];
	int             fcnt;
	logic [31:0]    ua [USED_ENTRIES];
	logic [31:0]    ul [USED_ENTRIES];
	logic           uv [USED_ENTRIES];
	ffca_pkg::rsp_t expected_q [$];

	function automatic void pool_rebuild();
		for (int k = 0; k < FREE_ENTRIES; k++) begin
			fs[k] = '0;
			fl[k] = '0;
		end
		for (int k = 0; k < USED_ENTRIES; k++) begin
			ua[k] = '0;
			ul[k] = '0;
			uv[k] = 1'b0;
		end
		fs[0] = base_q;
		fl[0] = plen_q;
		fcnt = 1;
	endfunction

	function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic ffca_pkg::status_t pool_alloc(input logic [31:0] nbytes,
			input logic [3:0] lg, output logic [31:0] got);
		logic [63:0] algn, pad, need;
		logic [31:0] s, a;
		int slot;
		got = '0;
		algn = 64'd1 << lg;
		for (int i = 0; i < FREE_ENTRIES; i++) begin
			if (i >= fcnt)
				break;
			s = fs[i];
			pad = (64'd0 - {32'd0, s}) & (algn - 64'd1);
			need = {32'd0, nbytes} + pad;
			if ({32'd0, fl[i]} < need)
				continue;
			a = s + pad[31:0];
			slot = -1;
			for (int k = 0; k < USED_ENTRIES; k++)
				if (uv[k] && ua[k] == a) begin
					slot = k;
					break;
				end
			if (slot < 0)
				for (int k = 0; k < USED_ENTRIES; k++)
					if (!uv[k]) begin
						slot = k;
						break;
					end
			if (slot < 0)
				return ffca_pkg::ST_FULL;
			if ({32'd0, fl[i]} > need) begin
				fs[i] = s + need[31:0];
				fl[i] = fl[i] - need[31:0];
			end else begin
				for (int k = i; k + 1 < fcnt; k++) begin
					fs[k] = fs[k + 1];
					fl[k] = fl[k + 1];
				end
				fcnt--;
			end
			uv[slot] = 1'b1;
			ua[slot] = a;
			ul[slot] = nbytes;
			got = a;
			return ffca_pkg::ST_OK;
		end
		return ffca_pkg::ST_NO_FIT;
	endfunction

	function automatic ffca_pkg::status_t pool_release(input logic [31:0] a);
		int r, pos;
		logic [31:0] len;
		logic mp, mn;
		r = -1;
		for (int k = 0; k < USED_ENTRIES; k++)
			if (uv[k] && ua[k] == a) begin
				r = k;
				break;
			end
		if (r < 0)
			return ffca_pkg::ST_NOT_ALLOC;
		len = ul[r];
		if (len == 0) begin
			uv[r] = 1'b0;
			return ffca_pkg::ST_OK;
		end
		pos = 0;
		while (pos < fcnt && fs[pos] <= a)
			pos++;
		mp = pos > 0 && (fs[pos - 1] + fl[pos - 1]) == a;
		mn = pos < fcnt && (a + len) == fs[pos];
		if (mp && mn) begin
			fl[pos - 1] = sat_sum(sat_sum(fl[pos - 1], len), fl[pos]);
			for (int k = pos; k + 1 < fcnt; k++) begin
				fs[k] = fs[k + 1];
				fl[k] = fl[k + 1];
			end
			fcnt--;
		end else if (mp) begin
			fl[pos - 1] = sat_sum(fl[pos - 1], len);
		end else if (mn) begin
			fs[pos] = a;
			fl[pos] = sat_sum(fl[pos], len);
		end else begin
			if (fcnt >= FREE_ENTRIES)
				return ffca_pkg::ST_FULL;
			for (int k = fcnt; k > pos; k--) begin
				fs[k] = fs[k - 1];
				fl[k] = fl[k - 1];
			end
			fs[pos] = a;
			fl[pos] = len;
			fcnt++;
		end
		uv[r] = 1'b0;
		return ffca_pkg::ST_OK;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ffca_pkg::rsp_t exp_rsp, got_rsp;
		logic [31:0] a;
		if (!arst_n) begin
			base_q = '0;
			plen_q = '0;
			pool_rebuild();
			expected_q.delete();
			errors = 0;
			n_alloc = 0;
			n_free = 0;
			for (int k = 0; k < 4; k++)
				n_status[k] = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == ffca_pkg::CFG_POOL_BASE)
					base_q = cfg_data;
				else if (cfg_index == ffca_pkg::CFG_POOL_LENGTH)
					plen_q = cfg_data;
				if (cfg_index == ffca_pkg::CFG_POOL_BASE ||
						cfg_index == ffca_pkg::CFG_POOL_LENGTH)
					pool_rebuild();
			end
			if (req_valid && req_ready) begin
				a = '0;
				if (req.command == ffca_pkg::CMD_ALLOC) begin
					exp_rsp.status = pool_alloc(req.request_bytes, req.align_log2, a);
					n_alloc++;
				end else begin
					exp_rsp.status = pool_release(req.free_address);
					n_free++;
				end
				exp_rsp.address = (exp_rsp.status == ffca_pkg::ST_OK) ? a : '0;
				expected_q.push_back(exp_rsp);
			end
			if (rsp_valid && rsp_ready) begin
				got_rsp = rsp;
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected response status=%0d address=%h",
							got_rsp.status, got_rsp.address);
				end else begin
					exp_rsp = expected_q.pop_front();
					n_status[exp_rsp.status]++;
					if (got_rsp.status !== exp_rsp.status ||
							got_rsp.address !== exp_rsp.address) begin
						errors++;
						if (errors <= 10)
							$display({"response mismatch: expected status=%0d ",
								"address=%h, got status=%0d address=%h"},
								exp_rsp.status, exp_rsp.address,
								got_rsp.status, got_rsp.address);
					end
				end
			end
		end
		pending = expected_q.size();
	end

endmodule

>>> test/tb_first_fit_coalescing_allocator.sv
// ----------------------------------------------------------------------------
// tb_first_fit_coalescing_allocator
// Drives allocate and free requests into the pool allocator across several
// pool settings with random idling and one long response stall; the checker
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_first_fit_coalescing_allocator;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RAND_PER_POOL = 165;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           req_valid = 1'b0;
	logic                           req_ready;
	ffca_pkg::req_t                 req = '0;
	logic                           rsp_valid;
	logic                           rsp_ready = 1'b0;
	ffca_pkg::rsp_t                 rsp;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [1:0]                     cfg_index = '0;
	logic [ffca_pkg::DATA_BITS-1:0] cfg_data = '0;

	int             errors, pending, n_alloc, n_free;
	int             n_status [4];
	int             cycles = 0;
	bit             calm = 1'b0;
	bit             hold_go = 1'b0;
	bit             hold_done = 1'b0;
	ffca_pkg::cmd_t sent_q [$];
	logic [31:0]    live_q [$];

	first_fit_coalescing_allocator i_dut (
		.clk, .arst_n, .req_valid, .req_ready, .req,
		.rsp_valid, .rsp_ready, .rsp, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	ffca_checker i_checker (
		.clk, .arst_n, .req_valid, .req_ready, .req,
		.rsp_valid, .rsp_ready, .rsp, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.errors, .pending, .n_alloc, .n_free, .n_status
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[first_fit_coalescing_allocator] ERROR");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off when asked
	always @(negedge clk) begin
		if (hold_go && !hold_done) begin
			rsp_ready <= 1'b0;
			repeat (400) @(negedge clk);
			hold_done = 1'b1;
		end else begin
			rsp_ready <= calm || ($urandom_range(99) >= 24);
		end
	end

	// remember granted addresses so frees mostly hit live records
	always @(posedge clk) begin
		ffca_pkg::cmd_t c;
		if (rsp_valid && rsp_ready && sent_q.size() != 0) begin
			c = sent_q.pop_front();
			if (c == ffca_pkg::CMD_ALLOC && rsp.status == ffca_pkg::ST_OK)
				live_q.push_back(rsp.address);
		end
	end

	task automatic send_request(input ffca_pkg::cmd_t c, input logic [31:0] nbytes,
			input logic [3:0] lg, input logic [31:0] fa);
		while (!calm && $urandom_range(99) < 24) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req <= '{command: c, request_bytes: nbytes, align_log2: lg, free_address: fa};
		do @(posedge clk); while (!req_ready);
		sent_q.push_back(c);
	endtask

	task automatic free_live(input logic [31:0] fallback);
		logic [31:0] a;
		int idx;
		if (live_q.size() != 0) begin
			idx = $urandom_range(live_q.size() - 1);
			a = live_q[idx];
			live_q.delete(idx);
		end else begin
			a = fallback;
		end
		send_request(ffca_pkg::CMD_FREE, $urandom, 4'($urandom), a);
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0 || sent_q.size() != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic write_reg(input ffca_pkg::cfg_reg_t idx, input logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_pool(input logic [31:0] b, input logic [31:0] len);
		drain();
		write_reg(ffca_pkg::CFG_POOL_BASE, b);
		write_reg(ffca_pkg::CFG_POOL_LENGTH, len);
		live_q.delete();
	endtask

	task automatic random_request();
		logic [31:0] nbytes;
		logic [3:0] lg;
		int pick;
		if ($urandom_range(99) < 58) begin
			pick = $urandom_range(99);
			nbytes = (pick < 80) ? $urandom_range(64) : (pick < 90) ? 32'd0 : $urandom;
			lg = ($urandom_range(99) < 85) ? 4'($urandom_range(4)) : 4'($urandom_range(15));
			send_request(ffca_pkg::CMD_ALLOC, nbytes, lg, $urandom);
		end else if ($urandom_range(99) < 85) begin
			free_live($urandom);
		end else begin
			send_request(ffca_pkg::CMD_FREE, $urandom, 4'($urandom), $urandom);
		end
	endtask

	logic [31:0] pool_base_list [6];
	logic [31:0] pool_len_list [6];

	initial begin
		pool_base_list = '{32'h0000_1000, 32'hFFFF_FFFF, 32'hFFFF_FF00, 32'h0,
			32'h0, 32'h0};
		pool_len_list = '{32'h400, 32'hFFFF_FFFF, 32'h200, 32'hFFFF_FFFF,
			32'h0, 32'h0};
		pool_base_list[5] = $urandom;
		pool_len_list[5] = $urandom_range(4096, 256);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		// directed: small pool, zero size, alignment corners, unknown address
		set_pool(32'h0000_1000, 32'h100);
		send_request(ffca_pkg::CMD_ALLOC, 32'd0, 4'd0, 32'd0);
		send_request(ffca_pkg::CMD_ALLOC, 32'd0, 4'd0, 32'd0);
		send_request(ffca_pkg::CMD_ALLOC, 32'd16, 4'd4, 32'd0);
		send_request(ffca_pkg::CMD_ALLOC, 32'd1, 4'd15, 32'hFFFF_FFFF);
		send_request(ffca_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 4'd0, 32'd0);
		send_request(ffca_pkg::CMD_ALLOC, 32'd8, 4'd12, 32'd0);
		send_request(ffca_pkg::CMD_ALLOC, 32'd8, 4'd3, 32'd0);
		send_request(ffca_pkg::CMD_FREE, 32'hFFFF_FFFF, 4'hF, 32'hDEAD_BEEF);
		send_request(ffca_pkg::CMD_FREE, 32'd0, 4'd0, 32'h0000_1010);
		send_request(ffca_pkg::CMD_FREE, 32'd0, 4'd0, 32'h0000_1020);
		send_request(ffca_pkg::CMD_FREE, 32'd0, 4'd0, 32'h0000_1000);
		send_request(ffca_pkg::CMD_FREE, 32'd0, 4'd0, 32'h0000_1000);
		send_request(ffca_pkg::CMD_ALLOC, 32'h100, 4'd0, 32'd0);
		send_request(ffca_pkg::CMD_ALLOC, 32'd0, 4'd0, 32'd0);
		send_request(ffca_pkg::CMD_FREE, 32'd0, 4'd0, 32'h0000_1000);
		// empty pool takes one zero-byte unpadded request
		set_pool(32'h0000_0007, 32'h0);
		send_request(ffca_pkg::CMD_ALLOC, 32'd0, 4'd3, 32'd0);
		send_request(ffca_pkg::CMD_ALLOC, 32'd0, 4'd0, 32'd0);
		send_request(ffca_pkg::CMD_ALLOC, 32'd0, 4'd0, 32'd0);
		// whole address space, wraps and saturating merges
		set_pool(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(ffca_pkg::CMD_ALLOC, 32'd1, 4'd0, 32'd0);
		send_request(ffca_pkg::CMD_ALLOC, 32'h10, 4'd13, 32'd0);
		send_request(ffca_pkg::CMD_FREE, 32'd0, 4'd0, 32'hFFFF_FFFF);
		send_request(ffca_pkg::CMD_FREE, 32'd0, 4'd0, 32'h0000_0000);

		for (int p = 0; p < 6; p++) begin
			set_pool(pool_base_list[p], pool_len_list[p]);
			for (int n = 0; n < RAND_PER_POOL; n++) begin
				calm = (p == 2);
				if (p == 3 && n == 40)
					hold_go = 1'b1;
				random_request();
			end
			calm = 1'b0;
		end

		drain();
		$display("%0d allocate and %0d free requests over nine pool settings, long stall %s",
			n_alloc, n_free, hold_done ? "done" : "skipped");
		$display("status ok=%0d no_fit=%0d not_alloc=%0d full=%0d",
			n_status[ffca_pkg::ST_OK], n_status[ffca_pkg::ST_NO_FIT],
			n_status[ffca_pkg::ST_NOT_ALLOC], n_status[ffca_pkg::ST_FULL]);
		if (errors == 0)
			$display("[first_fit_coalescing_allocator] OK");
		else
			$display("[first_fit_coalescing_allocator] ERROR");
		$finish;
	end

endmodule

>>> sim.f
src/ffca_pkg.sv
src/ffca_alu.sv
src/ffca_used_tbl.sv
src/first_fit_coalescing_allocator.sv
test/ffca_checker.sv
test/tb_first_fit_coalescing_allocator.sv
